// ===== design/fixed_point_alu_with_sqrt_core_macros.svh =====
// assertion macros for the fixed-point alu checker
`ifndef FIXED_POINT_ALU_WITH_SQRT_CORE_MACROS_SVH
`define FIXED_POINT_ALU_WITH_SQRT_CORE_MACROS_SVH

// clocked assertion, off while reset is high
`define FPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also runs through reset
`define FPA_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
// shared codes, constants and queue word type of the fixed-point alu
package fpa_pkg;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_ADD3   = 3'd1;
   localparam logic [2:0] ACT_SUB    = 3'd2;
   localparam logic [2:0] ACT_MUL    = 3'd3;
   localparam logic [2:0] ACT_DIV    = 3'd4;
   localparam logic [2:0] ACT_SQUARE = 3'd5;
   localparam logic [2:0] ACT_INV    = 3'd6;
   localparam logic [2:0] ACT_SQRT   = 3'd7;

   // fixed-point scale; the inverse-root constants below assume 64
   localparam int FIX_SCALE = 64;
   localparam int FIX_SHIFT = $clog2(FIX_SCALE);

   localparam logic signed [31:0] INV_MAGIC    = 32'sd12288;
   localparam logic signed [31:0] THREE_HALVES = 32'sd96;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam int DIV_BITS = 64;
   localparam int DCNT_W   = 6;

   typedef struct packed {
      logic [2:0]         action;
      logic               fast;
      logic               fast_dz;
      logic signed [63:0] operand_a;
      logic signed [31:0] operand_b;
      logic signed [31:0] fast_result;
   } queue_item_type;

endpackage

// ===== design/fpa_if.sv =====
// request and response channel interfaces of the fixed-point alu
interface fpa_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [63:0] operand_a;
   logic signed [31:0] operand_b;
   logic signed [31:0] operand_c;

   modport source (output valid, action, operand_a, operand_b, operand_c, input ready);
   modport sink (input valid, action, operand_a, operand_b, operand_c, output ready);
endinterface

interface fpa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] result;
   logic               divide_by_zero;

   modport source (output valid, result, divide_by_zero, input ready);
   modport sink (input valid, result, divide_by_zero, output ready);
endinterface

// ===== design/fpa_front.sv =====
// front end: accepts request words, classifies them and queues them
module fpa_front import fpa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   fpa_req_if.sink        req_ch,
   output logic           pop_valid,
   input  logic           pop_ready,
   output queue_item_type pop_item
);

   queue_item_type          mem_ff [QUEUE_DEPTH];
   queue_item_type          item;
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    push;
   logic                    pop;
   logic signed [31:0]      a32;

   assign a32 = req_ch.operand_a[31:0];

   // simple ops are finished here; a zero divisor is flagged, a non-positive root gives zero
   always_comb begin
      item.action      = req_ch.action;
      item.operand_a   = req_ch.operand_a;
      item.operand_b   = req_ch.operand_b;
      item.fast        = 1'b0;
      item.fast_dz     = 1'b0;
      item.fast_result = '0;
      unique case (req_ch.action)
         ACT_ADD: begin
            item.fast        = 1'b1;
            item.fast_result = a32 + req_ch.operand_b;
         end
         ACT_ADD3: begin
            item.fast        = 1'b1;
            item.fast_result = a32 + req_ch.operand_b + req_ch.operand_c;
         end
         ACT_SUB: begin
            item.fast        = 1'b1;
            item.fast_result = a32 - req_ch.operand_b;
         end
         ACT_DIV: begin
            if (req_ch.operand_b == 32'sd0) begin
               item.fast    = 1'b1;
               item.fast_dz = 1'b1;
            end
         end
         ACT_SQRT: begin
            if (req_ch.operand_a <= 64'sd0) begin
               item.fast = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign pop_valid    = (count_ff != '0);
   assign pop          = pop_valid && pop_ready;
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/fpa_back.sv =====
// back end: sequencer with shared multiplier, radix-2 divider and output register
module fpa_back import fpa_pkg::*; #(
   parameter int SQRT_STEPS = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  queue_item_type pop_item,
   fpa_rsp_if.source      rsp_ch
);

   localparam logic [31:0] SCALE_W = 32'(FIX_SCALE);
   localparam int          IT_W    = $clog2(SQRT_STEPS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQS  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_POST = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         act_ff, act_in;
   logic [1:0]         phase_ff, phase_in;
   logic [IT_W-1:0]    iter_ff, iter_in;
   logic signed [31:0] opb_ff, opb_in;
   logic signed [31:0] lowv_ff, lowv_in;
   logic signed [63:0] x_ff, x_in;
   logic signed [31:0] h_ff, h_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] mop_a_ff, mop_a_in;
   logic signed [31:0] mop_b_ff, mop_b_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        num_ff, num_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        den_ff, den_in;
   logic               neg_ff, neg_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [63:0] res_ff, res_in;
   logic               dz_ff, dz_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [63:0] out_result_ff, out_result_in;
   logic               out_dz_ff, out_dz_in;

   logic               out_free;
   logic               out_load;
   logic signed [63:0] out_res;
   logic               out_dz;

   always_comb begin
      logic signed [31:0] a32;
      logic signed [31:0] hv;
      logic signed [31:0] x32;
      logic [63:0]        pmag;
      logic [32:0]        rem_sh;
      logic [63:0]        q;
      logic signed [31:0] q32;
      logic signed [64:0] sum;
      logic signed [63:0] xn;

      a32    = '0;
      hv     = '0;
      x32    = x_ff[31:0];
      pmag   = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      rem_sh = {rem_ff[31:0], num_ff[63]};
      q      = neg_ff ? 64'(-num_ff) : num_ff;
      q32    = q[31:0];
      sum    = {x_ff[63], x_ff} + {{33{q32[31]}}, q32};
      xn     = sum[64:1];

      state_in = state_ff;
      act_in   = act_ff;
      phase_in = phase_ff;
      iter_in  = iter_ff;
      opb_in   = opb_ff;
      lowv_in  = lowv_ff;
      x_in     = x_ff;
      h_in     = h_ff;
      y_in     = y_ff;
      mop_a_in = mop_a_ff;
      mop_b_in = mop_b_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      dz_in    = dz_ff;
      pop_ready = 1'b0;
      out_load  = 1'b0;
      out_res   = res_ff;
      out_dz    = dz_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_item.fast) begin
                  // finished in the front, goes straight to the output register
                  if (out_free) begin
                     pop_ready = 1'b1;
                     out_load  = 1'b1;
                     out_res   = 64'(signed'(pop_item.fast_result));
                     out_dz    = pop_item.fast_dz;
                  end
               end else begin
                  pop_ready = 1'b1;
                  a32       = pop_item.operand_a[31:0];
                  hv        = a32 >>> 1;
                  act_in    = pop_item.action;
                  opb_in    = pop_item.operand_b;
                  lowv_in   = a32;
                  x_in      = pop_item.operand_a;
                  h_in      = hv;
                  y_in      = INV_MAGIC - hv;
                  phase_in  = '0;
                  iter_in   = '0;
                  state_in  = ST_MUL;
                  case (pop_item.action)
                     ACT_MUL: begin
                        mop_a_in = a32;
                        mop_b_in = pop_item.operand_b;
                     end
                     ACT_SQUARE: begin
                        mop_a_in = a32;
                        mop_b_in = a32;
                     end
                     ACT_DIV: begin
                        mop_a_in = a32;
                        mop_b_in = SCALE_W;
                     end
                     ACT_INV: begin
                        mop_a_in = INV_MAGIC - hv;
                        mop_b_in = INV_MAGIC - hv;
                     end
                     default: begin
                        state_in = ST_SQS;
                     end
                  endcase
               end
            end
         end
         ST_SQS: begin
            // newton step: zero low word of x means a zero divisor
            if (x32 == 32'sd0) begin
               res_in   = '0;
               dz_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               mop_a_in = lowv_ff;
               mop_b_in = SCALE_W;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mop_a_ff * mop_b_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            num_in   = pmag;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
            case (act_ff)
               ACT_DIV: begin
                  den_in = opb_ff[31] ? 32'(-opb_ff) : 32'(opb_ff);
                  neg_in = prod_ff[63] ^ opb_ff[31];
               end
               ACT_SQRT: begin
                  den_in = x32[31] ? 32'(-x32) : 32'(x32);
                  neg_in = prod_ff[63] ^ x32[31];
               end
               default: begin
                  // scale divide truncates toward zero: shift the magnitude
                  num_in   = pmag >> FIX_SHIFT;
                  neg_in   = prod_ff[63];
                  state_in = ST_POST;
               end
            endcase
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_BITS - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            dz_in    = 1'b0;
            state_in = ST_DONE;
            case (act_ff)
               ACT_MUL, ACT_SQUARE: begin
                  res_in = q;
               end
               ACT_DIV: begin
                  res_in = 64'(q32);
               end
               ACT_INV: begin
                  case (phase_ff)
                     2'd0: begin
                        mop_a_in = h_ff;
                        mop_b_in = q32;
                        phase_in = 2'd1;
                        state_in = ST_MUL;
                     end
                     2'd1: begin
                        mop_a_in = y_ff;
                        mop_b_in = THREE_HALVES - q32;
                        phase_in = 2'd2;
                        state_in = ST_MUL;
                     end
                     default: begin
                        res_in = 64'(q32);
                     end
                  endcase
               end
               default: begin
                  x_in = xn;
                  if (iter_ff == IT_W'(SQRT_STEPS - 1)) begin
                     res_in = 64'(signed'(xn[31:0]));
                  end else begin
                     iter_in  = iter_ff + 1'b1;
                     state_in = ST_SQS;
                  end
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register frees the sequencer from the receiver
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      out_dz_in     = out_dz_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_result_in = out_res;
         out_dz_in     = out_dz;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.result         = out_result_ff;
   assign rsp_ch.divide_by_zero = out_dz_ff;

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      phase_ff      <= phase_in;
      iter_ff       <= iter_in;
      opb_ff        <= opb_in;
      lowv_ff       <= lowv_in;
      x_ff          <= x_in;
      h_ff          <= h_in;
      y_ff          <= y_in;
      mop_a_ff      <= mop_a_in;
      mop_b_ff      <= mop_b_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      dz_ff         <= dz_in;
      out_result_ff <= out_result_in;
      out_dz_ff     <= out_dz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== design/fixed_point_alu_with_sqrt_core.sv =====
// top level of the fixed-point alu with newton square root
//
// usage
// - req_ch carries one word per operation: action, operand_a, operand_b, operand_c
// - rsp_ch returns one word per operation in order: result, divide_by_zero
// - both channels move a word when valid and ready are high at a rising edge
// - add, add3, sub and the zero-divisor / non-positive root cases are finished
//   in the front and leave 1 per cycle while the sequencer idles, ready high
// - mul and square use one multiply and a shift by the scale; the sequencer
//   passes them through its mul, load, post and done states
// - div adds a 64-step radix-2 divide after the multiply by the scale
// - inv_sqrt chains three multiply-and-shift passes
// - sqrt runs SQRT_STEPS newton steps, each a multiply and a divide by x
// - the sequencer does one long operation at a time; the 4-word queue keeps
//   taking requests meanwhile, one per cycle until it fills
// - the output register holds a word while rsp_ch.ready is low; the back end
//   finishes the next word and waits on it, the queue keeps filling
// - synchronous reset empties the queue, idles the sequencer, drops rsp valid
module fixed_point_alu_with_sqrt_core import fpa_pkg::*; #(
   parameter int SQRT_STEPS = 5
) (
   input logic       clock,
   input logic       reset,
   fpa_req_if.sink   req_ch,
   fpa_rsp_if.source rsp_ch
);

   logic           pop_valid;
   logic           pop_ready;
   queue_item_type pop_item;

   // classification and queue
   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   // arithmetic sequencer and output register
   fpa_back #(
      .SQRT_STEPS (SQRT_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== design/fpa_checker.sv =====
// port-level checks of the fixed-point alu and their binding
`include "fixed_point_alu_with_sqrt_core_macros.svh"

module fpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result,
   input logic        rsp_divide_by_zero
);

   `FPA_ASSERT_RST(a_reset_drops_valid, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `FPA_ASSERT(a_dz_gives_zero, clock, reset, rsp_valid && rsp_divide_by_zero |-> rsp_result == 64'd0, "zero divisor with nonzero result")
   `FPA_ASSERT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
   `FPA_ASSERT(a_word_holds, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_divide_by_zero), "rsp word changed while stalled")

endmodule

bind fixed_point_alu_with_sqrt_core fpa_checker u_fpa_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_result         (rsp_ch.result),
   .rsp_divide_by_zero (rsp_ch.divide_by_zero)
);
